FILE: rtl/hash_chain_replay_check_macros.svh
// Assertion macros for the hash chain replay check block.
`ifndef HASH_CHAIN_REPLAY_CHECK_MACROS_SVH
`define HASH_CHAIN_REPLAY_CHECK_MACROS_SVH
// Assert that a condition implies another one in the same cycle.
`define HCRC_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// Assert that a condition implies another one in the next cycle.
`define HCRC_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

FILE: rtl/hcrc_pkg.sv
// Package with SHA-256 constants, codes and types for the hash chain replay check.
package hcrc_pkg;
	localparam logic [1:0] VERDICT_OK       = 2'd0;
	localparam logic [1:0] VERDICT_REPLAY   = 2'd1;
	localparam logic [1:0] VERDICT_TOO_FAR  = 2'd2;
	localparam logic [1:0] VERDICT_MISMATCH = 2'd3;

	localparam logic [2:0] REG_MAX_GAP = 3'd0;
	localparam logic [2:0] REG_TAIL_0  = 3'd1;
	localparam logic [2:0] REG_TAIL_3  = 3'd4;

	localparam logic [31:0] HASH_LEN_BITS = 32'd256;

	typedef logic [255:0] hash_t;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
endpackage

FILE: rtl/hash_chain_replay_check.sv
// Hash chain replay check: id window test and iterated SHA-256 chain walk.
// The id of each item is checked first; a replay or too-far id answers
// at once. An id that passes is walked back gap times through one SHA-256
// round unit that does one round a cycle, each hash being a load, 64
// rounds and a final add, gap being the id advance over the stored id.
// The next item is taken once the result register is free.
module hash_chain_replay_check #(
	parameter int ID_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// message_id[31:0], hash_word_0[95:32], hash_word_1, hash_word_2, hash_word_3[287:224]
	input  logic [287:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// accepted[0], verdict[2:1], zero fill [7:3]
	output logic [7:0]   m_tdata
);
	import hcrc_pkg::*;
	`include "hash_chain_replay_check_macros.svh"

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_LOAD  = 2'd1;
	localparam logic [1:0] ST_ROUND = 2'd2;
	localparam logic [1:0] ST_FINAL = 2'd3;

	logic [1:0]         state_q;
	logic [15:0]        max_gap_q;
	hash_t              tail_q;
	logic               have_stored_q;
	logic [ID_BITS-1:0] stored_id_q;
	hash_t              stored_hash_q;
	hash_t              in_hash_q;
	logic [ID_BITS-1:0] in_id_q;
	hash_t              work_q;
	logic [31:0]        st_q [8];
	logic [31:0]        w_q [16];
	logic [5:0]         round_q;
	logic [15:0]        steps_q;
	logic               out_valid_q;
	logic               out_acc_q;
	logic [1:0]         out_verdict_q;

	logic [ID_BITS-1:0] in_id;
	logic [ID_BITS-1:0] ref_id;
	logic [ID_BITS-1:0] gap;
	hash_t              in_hash;
	hash_t              ref_hash;
	logic               take;
	logic               gap_too_far;

	assign in_id = s_tdata[ID_BITS-1:0];
	assign in_hash = s_tdata[287:32];
	assign ref_id = have_stored_q ? stored_id_q : '0;
	assign ref_hash = have_stored_q ? stored_hash_q : tail_q;
	assign gap = in_id - ref_id;
	assign s_tready = (state_q == ST_IDLE) && !out_valid_q;
	assign take = s_tvalid && s_tready;
	if (ID_BITS > 16) begin : g_wide
		assign gap_too_far = (gap[ID_BITS-1:16] != '0) || (gap[15:0] > max_gap_q);
	end else begin : g_narrow
		assign gap_too_far = 16'(gap) > max_gap_q;
	end

	// Round unit: message schedule word and compression round
	logic [31:0] wt, s0, s1, w_next, t1, t2, e, a;
	always_comb begin
		wt = w_q[0];
		s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
		s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
			^ (w_q[14] >> 10);
		w_next = w_q[0] + s0 + w_q[9] + s1;
		e = st_q[4];
		a = st_q[0];
		t1 = st_q[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
			+ ((e & st_q[5]) ^ (~e & st_q[6])) + ROUND_K[round_q] + wt;
		t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
			+ ((a & st_q[1]) ^ (a & st_q[2]) ^ (st_q[1] & st_q[2]));
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gap_q <= 16'd16;
			tail_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_MAX_GAP) max_gap_q <= cfg_wdata[15:0];
			else if (cfg_index >= REG_TAIL_0 && cfg_index <= REG_TAIL_3)
				tail_q[(255 - 64 * (int'(cfg_index) - 1)) -: 64] <= cfg_wdata;
		end
	end

	// Sequence the id check, chain walk and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			have_stored_q <= 1'b0;
			stored_id_q <= '0;
			out_valid_q <= 1'b0;
			round_q <= '0;
			steps_q <= '0;
		end else begin
			if (m_tvalid && m_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						in_id_q <= in_id;
						in_hash_q <= {in_hash[63:0], in_hash[127:64], in_hash[191:128],
							in_hash[255:192]};
						work_q <= {in_hash[63:0], in_hash[127:64], in_hash[191:128],
							in_hash[255:192]};
						steps_q <= 16'(gap);
						if (in_id <= ref_id) begin
							out_valid_q <= 1'b1;
							out_acc_q <= 1'b0;
							out_verdict_q <= VERDICT_REPLAY;
						end else if (gap_too_far) begin
							out_valid_q <= 1'b1;
							out_acc_q <= 1'b0;
							out_verdict_q <= VERDICT_TOO_FAR;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					if (steps_q == '0) begin
						out_valid_q <= 1'b1;
						if (work_q == ref_hash) begin
							out_acc_q <= 1'b1;
							out_verdict_q <= VERDICT_OK;
							stored_hash_q <= in_hash_q;
							stored_id_q <= in_id_q;
							have_stored_q <= 1'b1;
						end else begin
							out_acc_q <= 1'b0;
							out_verdict_q <= VERDICT_MISMATCH;
						end
						state_q <= ST_IDLE;
					end else begin
						for (int i = 0; i < 8; i++) begin
							w_q[i] <= work_q[255 - 32 * i -: 32];
							st_q[i] <= INIT_H[i];
						end
						w_q[8] <= 32'h80000000;
						for (int i = 9; i < 15; i++) w_q[i] <= '0;
						w_q[15] <= HASH_LEN_BITS;
						round_q <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= w_next;
					st_q[7] <= st_q[6]; st_q[6] <= st_q[5]; st_q[5] <= st_q[4];
					st_q[4] <= st_q[3] + t1;
					st_q[3] <= st_q[2]; st_q[2] <= st_q[1]; st_q[1] <= st_q[0];
					st_q[0] <= t1 + t2;
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) state_q <= ST_FINAL;
				end
				ST_FINAL: begin
					for (int i = 0; i < 8; i++)
						work_q[255 - 32 * i -: 32] <= st_q[i] + INIT_H[i];
					steps_q <= steps_q - 16'd1;
					state_q <= ST_LOAD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {5'd0, out_verdict_q, out_acc_q};

	`HCRC_ASSERT_IMP(a_busy_not_ready, clk, arst_n, state_q != ST_IDLE, !s_tready)
	`HCRC_ASSERT_IMP(a_acc_verdict, clk, arst_n, m_tvalid, out_acc_q == (out_verdict_q == VERDICT_OK))
	`HCRC_ASSERT_NEXT(a_round_end, clk, arst_n, state_q == ST_ROUND && round_q == 6'd63,
		state_q == ST_FINAL)
	`HCRC_ASSERT_IMP(a_no_result_in_walk, clk, arst_n, state_q == ST_ROUND, !m_tvalid)
endmodule

FILE: tb/sv/hash_chain_replay_check_checker.sv
// Chain hash helper package and the result checker for the hash chain replay check.
package hcrc_tb_pkg;
	import hcrc_pkg::*;

	function automatic logic [31:0] rotr(logic [31:0] x, int n);
		logic [63:0] d;
		d = {x, x} >> n;
		return d[31:0];
	endfunction

	// Hash one 32-byte value, big-endian, as {word0, word1, word2, word3}.
	function automatic hash_t sha256_of_hash(hash_t v);
		logic [31:0] w [64];
		logic [31:0] s [8];
		logic [31:0] t1, t2, s0, s1;
		hash_t r;
		for (int i = 0; i < 8; i++)
			w[i] = v[255 - 32 * i -: 32];
		w[8] = 32'h80000000;
		for (int i = 9; i < 15; i++)
			w[i] = '0;
		w[15] = HASH_LEN_BITS;
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(w[i - 15], 7) ^ rotr(w[i - 15], 18) ^ (w[i - 15] >> 3);
			s1 = rotr(w[i - 2], 17) ^ rotr(w[i - 2], 19) ^ (w[i - 2] >> 10);
			w[i] = w[i - 16] + s0 + w[i - 7] + s1;
		end
		for (int i = 0; i < 8; i++)
			s[i] = INIT_H[i];
		for (int i = 0; i < 64; i++) begin
			t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
				+ ((s[4] & s[5]) ^ (~s[4] & s[6])) + ROUND_K[i] + w[i];
			t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
				+ ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
			s[7] = s[6]; s[6] = s[5]; s[5] = s[4];
			s[4] = s[3] + t1;
			s[3] = s[2]; s[2] = s[1]; s[1] = s[0];
			s[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			r[255 - 32 * i -: 32] = s[i] + INIT_H[i];
		return r;
	endfunction
endpackage

module hash_chain_replay_check_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_wdata,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [287:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [7:0]   m_tdata,
	output int           errors,
	output int           pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import hcrc_pkg::*;
	import hcrc_tb_pkg::*;

	typedef struct packed {
		logic       accepted;
		logic [1:0] verdict;
	} outcome_t;

	outcome_t    outcome_q [$];
	logic [15:0] gap_limit;
	hash_t       tail_hash;
	logic        anchored;
	logic [31:0] anchor_id;
	hash_t       anchor_hash;

	// Decide one message against the stored pair; update the pair on acceptance.
	function automatic outcome_t judge_message(logic [31:0] id, hash_t h);
		logic [31:0] base_id;
		hash_t base_hash, walk;
		outcome_t o;
		base_id = anchored ? anchor_id : '0;
		base_hash = anchored ? anchor_hash : tail_hash;
		o.accepted = 1'b0;
		if (id <= base_id)
			o.verdict = VERDICT_REPLAY;
		else if (id - base_id > {16'd0, gap_limit})
			o.verdict = VERDICT_TOO_FAR;
		else begin
			walk = h;
			for (logic [31:0] k = 0; k < id - base_id; k++)
				walk = sha256_of_hash(walk);
			if (walk != base_hash)
				o.verdict = VERDICT_MISMATCH;
			else begin
				o.verdict = VERDICT_OK;
				o.accepted = 1'b1;
				anchored = 1'b1;
				anchor_id = id;
				anchor_hash = h;
			end
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t exp_o, got;
		if (!arst_n) begin
			gap_limit = 16'd16;
			tail_hash = '0;
			anchored = 1'b0;
			anchor_id = '0;
			anchor_hash = '0;
			outcome_q.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			// Track register writes
			if (cfg_we) begin
				if (cfg_index == REG_MAX_GAP)
					gap_limit = cfg_wdata[15:0];
				else if (cfg_index >= REG_TAIL_0 && cfg_index <= REG_TAIL_3)
					tail_hash[255 - 64 * (cfg_index - REG_TAIL_0) -: 64] = cfg_wdata;
			end
			// Predict each accepted message
			if (s_tvalid && s_tready)
				outcome_q.push_back(judge_message(s_tdata[31:0],
					{s_tdata[95:32], s_tdata[159:96], s_tdata[223:160], s_tdata[287:224]}));
			// Compare each result with the oldest prediction
			if (m_tvalid && m_tready) begin
				got.accepted = m_tdata[0];
				got.verdict = m_tdata[2:1];
				if (outcome_q.size() == 0) begin
					$error("unexpected result: accepted %0d verdict %0d", got.accepted,
						got.verdict);
					errors <= errors + 1;
				end else begin
					exp_o = outcome_q.pop_front();
					if (got.accepted !== exp_o.accepted || got.verdict !== exp_o.verdict)
						errors <= errors + 1;
					if (got.accepted !== exp_o.accepted)
						$error("accepted: expected %0d, actual %0d", exp_o.accepted,
							got.accepted);
					if (got.verdict !== exp_o.verdict)
						$error("verdict: expected %0d, actual %0d", exp_o.verdict,
							got.verdict);
				end
			end
			pending <= outcome_q.size();
		end
	end
endmodule

FILE: tb/sv/testbench.sv
// Stimulus, clock, reset and verdict for the hash chain replay check.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import hcrc_pkg::*;
	import hcrc_tb_pkg::*;

	localparam int CHAIN_LEN = 1600;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [63:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [287:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [7:0]   m_tdata;
	int           errors;
	int           pending;

	hash_t        link_hash [0:CHAIN_LEN];
	logic [31:0]  chain_id;
	logic [15:0]  gap_now;
	logic         busy_sides;

	hash_chain_replay_check dut (.*);

	hash_chain_replay_check_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	// Stall the result side at random, or never while idling is off
	initial begin
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = busy_sides ? $urandom_range(0, 4) : 0;
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	function automatic hash_t random_hash();
		return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_MAX_GAP)
			gap_now = val[15:0];
	endtask

	task automatic write_tail(hash_t h);
		for (int k = 0; k < 4; k++)
			write_reg(3'(REG_TAIL_0 + k), h[255 - 64 * k -: 64]);
	endtask

	task automatic send_item(logic [31:0] id, hash_t h);
		int n;
		n = busy_sides ? $urandom_range(0, 4) : 0;
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_tdata <= {h[63:0], h[127:64], h[191:128], h[255:192], id};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// Send a chain link that should be accepted; the stored id moves with it
	task automatic send_link(logic [31:0] id);
		send_item(id, link_hash[CHAIN_LEN - id]);
		chain_id = id;
	endtask

	// Drain all results, then hold the block idle
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic random_item();
		int kind;
		logic [31:0] id, lim;
		kind = $urandom_range(0, 99);
		lim = (gap_now > 4) ? 4 : gap_now;
		if (kind < 55 && lim != 0) begin
			id = chain_id + $urandom_range(1, lim);
			if (id <= CHAIN_LEN)
				send_link(id);
			else
				send_item(chain_id, random_hash());
		end else if (kind < 67) begin
			send_item($urandom_range(0, chain_id), random_hash());
		end else if (kind < 79) begin
			send_item($urandom_range(chain_id + gap_now + 1, 32'hffffffff), random_hash());
		end else if (kind < 90 && lim != 0) begin
			// wrong hash within the window: off-by-one link or random bits
			id = chain_id + $urandom_range(1, lim);
			if ($urandom_range(0, 1) && id < CHAIN_LEN)
				send_item(id, link_hash[CHAIN_LEN - id - 1]);
			else
				send_item(id, random_hash());
		end else begin
			// noise, kept out of the walk window to bound the run
			id = $urandom;
			if (id > chain_id && id - chain_id <= gap_now)
				id = chain_id;
			send_item(id, random_hash());
		end
	endtask

	task automatic random_run(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				busy_sides = ($urandom_range(0, 3) != 0);
			random_item();
		end
		busy_sides = 1'b1;
	endtask

	initial begin
		hash_t junk;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		busy_sides = 1'b1;
		gap_now = 16'd16;
		chain_id = '0;
		link_hash[0] = random_hash();
		for (int k = 1; k <= CHAIN_LEN; k++)
			link_hash[k] = sha256_of_hash(link_hash[k - 1]);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes against the reset tail of zero
		send_item(32'd0, '0);
		send_item(32'hffffffff, '1);
		send_item(32'd1, '0);
		settle();
		junk = random_hash();
		write_tail(junk);
		write_tail(link_hash[CHAIN_LEN]);
		send_item(32'd1, random_hash());
		send_item(32'd17, link_hash[CHAIN_LEN - 17]);
		send_link(32'd16);
		send_item(32'd16, link_hash[CHAIN_LEN - 16]);
		send_item(32'd33, link_hash[CHAIN_LEN - 33]);
		send_link(32'd17);
		settle();
		// Tail rewrite after acceptance must be ignored
		write_tail('1);
		send_link(32'd18);
		send_link(32'd20);
		settle();
		// Zero gap limit: anything past the stored id is too far
		write_reg(REG_MAX_GAP, 64'd0);
		send_item(chain_id + 1, link_hash[CHAIN_LEN - chain_id - 1]);
		send_item(chain_id, '0);
		send_item(32'hffffffff, random_hash());
		random_run(30);
		settle();

		write_reg(REG_MAX_GAP, 64'd16);
		random_run(120);
		settle();
		write_reg(REG_MAX_GAP, 64'd1);
		random_run(110);
		settle();
		write_reg(REG_MAX_GAP, 64'hffff);
		write_tail(random_hash());
		random_run(110);
		settle();
		for (int p = 0; p < 2; p++) begin
			write_reg(REG_MAX_GAP, 64'($urandom_range(1, 20)));
			random_run(95);
			settle();
		end

		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
